// ----- design/fir16_pkg.sv -----
// Shared types and constants for the 16-tap FIR filter.
// No dependencies; imported by every module of the block.
package fir16_pkg;

    localparam int SAMPLE_W    = 16;                 // sample and coefficient width
    localparam int PROD_W      = 2 * SAMPLE_W;       // one tap product
    localparam int ACC_W       = PROD_W + 4;         // exact sum of up to 16 products
    localparam int COEF_REGS   = 4;                  // coefficient registers
    localparam int COEF_PER_REG = 4;                 // coefficients packed per register
    localparam int CFG_W       = SAMPLE_W * COEF_PER_REG;
    localparam int CFG_IDX_W   = $clog2(COEF_REGS);
    localparam int MAX_TAPS    = COEF_REGS * COEF_PER_REG;
    localparam int DEF_TAPS    = 16;
    localparam int DEF_OUT_SHIFT = 12;

    // Pipeline control handed to every cell and the adder tree.
    typedef struct packed {
        logic advance;   // whole pipe moves one stage
        logic take;      // an input beat is accepted this cycle
    } fir16_ctl_t;

endpackage

// ----- design/fir16_cell.sv -----
// One tap of the delay line: holds a past sample and forms its product.
// Depends on fir16_pkg.
module fir16_cell
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fir16_pkg::fir16_ctl_t                 ctl,
    input  logic signed [fir16_pkg::SAMPLE_W-1:0] din,    // sample seen by this tap
    input  logic signed [fir16_pkg::SAMPLE_W-1:0] coef,
    output logic signed [fir16_pkg::SAMPLE_W-1:0] tap_out, // to the next cell
    output logic signed [fir16_pkg::PROD_W-1:0]   product
);
    import fir16_pkg::*;

    logic signed [SAMPLE_W-1:0] tap_reg;
    logic signed [PROD_W-1:0]   product_reg;
    logic signed [PROD_W-1:0]   product_next;

    assign product_next = din * coef;

    // history moves only on accepted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (ctl.take)
        begin
            tap_reg <= din;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            product_reg <= product_next;
        end
    end

    assign tap_out = tap_reg;
    assign product = product_reg;

endmodule

// ----- design/fir16_sum.sv -----
// Registered binary adder tree over the tap products, one level per stage.
// Depends on fir16_pkg.
module fir16_sum #(
    parameter int TAPS = fir16_pkg::DEF_TAPS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir16_pkg::fir16_ctl_t               ctl,
    input  logic                                in_valid,
    input  logic signed [fir16_pkg::PROD_W-1:0] products [TAPS],
    output logic                                sum_valid,
    output logic signed [fir16_pkg::ACC_W-1:0]  sum
);
    import fir16_pkg::*;

    localparam int LEVELS = $clog2(TAPS);
    localparam int LEAVES = 1 << LEVELS;

    logic signed [ACC_W-1:0] leaf [LEAVES];
    // heap order: node 1 is the root, children of j are 2j and 2j+1
    logic signed [ACC_W-1:0] node_reg [1:LEAVES-1];
    logic [LEVELS-1:0]       vld_reg;

    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < TAPS)
            begin
                leaf[i] = ACC_W'(products[i]);
            end
            else
            begin
                leaf[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            for (int j = 1; j < LEAVES; j++)
            begin
                if (2 * j >= LEAVES)
                begin
                    node_reg[j] <= leaf[2 * j - LEAVES] + leaf[2 * j + 1 - LEAVES];
                end
                else
                begin
                    node_reg[j] <= node_reg[2 * j] + node_reg[2 * j + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.advance)
        begin
            vld_reg <= (vld_reg << 1) | LEVELS'(in_valid);
        end
    end

    assign sum       = node_reg[1];
    assign sum_valid = vld_reg[LEVELS-1];

endmodule

// ----- design/fir_filter_16tap_q12.sv -----
// Top level of the direct-form FIR filter: coefficient registers, tap cells,
// adder tree and output register. Depends on fir16_pkg, fir16_cell, fir16_sum.
//
// Direct-form FIR, TAPS taps of signed 16-bit samples times signed 16-bit
// coefficients, exact 36-bit sum, arithmetic shift right by OUT_SHIFT, low 16
// bits out (wrapping). One sample beat is taken every clock while the output
// is not stalled; an accepted input beat passes the product register, the
// adder-tree levels and the output register before it leaves the block. The
// whole pipe, including the delay line, freezes while the output beat is held
// by m_tready low. Coefficients sit four to a 64-bit register, tap 4*i+j in
// bits 16*j+15:16*j of register i; write them only while the filter is idle.
// The delay line clears to zero at reset, as do all coefficients.
module fir_filter_16tap_q12 #(
    parameter int TAPS      = fir16_pkg::DEF_TAPS,
    parameter int OUT_SHIFT = fir16_pkg::DEF_OUT_SHIFT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fir16_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
    // filtered stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fir16_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] filtered
    // coefficient writes
    input  logic                               cfg_we,
    input  logic [fir16_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fir16_pkg::CFG_W-1:0]        cfg_data
);
    import fir16_pkg::*;

    logic [CFG_W-1:0]           coef_reg [COEF_REGS];
    logic signed [SAMPLE_W-1:0] chain [TAPS];     // sample seen by each cell
    logic signed [PROD_W-1:0]   products [TAPS];
    logic signed [SAMPLE_W-1:0] coefs [TAPS];
    fir16_ctl_t                 ctl;
    logic                       prod_vld_reg;
    logic                       sum_valid;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ACC_W-1:0]    scaled;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;

    assign ctl.advance = !out_valid_reg || m_tready;
    assign ctl.take    = s_tvalid && ctl.advance;
    assign s_tready    = ctl.advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    assign chain[0] = $signed(s_tdata);

    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        localparam int REG_SEL = k / COEF_PER_REG;
        localparam int LANE    = k % COEF_PER_REG;

        assign coefs[k] = $signed(coef_reg[REG_SEL][LANE * SAMPLE_W +: SAMPLE_W]);

        if (k < TAPS - 1)
        begin : g_mid
            fir16_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .din     (chain[k]),
                .coef    (coefs[k]),
                .tap_out (chain[k + 1]),
                .product (products[k])
            );
        end
        else
        begin : g_last
            fir16_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .din     (chain[k]),
                .coef    (coefs[k]),
                .tap_out (),
                .product (products[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            prod_vld_reg <= s_tvalid;
        end
    end

    fir16_sum #(
        .TAPS (TAPS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_valid  (prod_vld_reg),
        .products  (products),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // floor shift, then keep the low bits
    assign scaled = sum >>> OUT_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            out_data_reg <= scaled[SAMPLE_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
